[rtl/core/hsm_pkg.sv]
// hsm_pkg: shared types and constants for the hall sensor monitor
// no dependencies; imported by hsm_window and hall_sensor_monitor
`default_nettype none

package hsm_pkg;

  // field widths fixed by the transaction format
  localparam int unsigned SampleW = 12;
  localparam int unsigned MvW     = 13;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  // full-scale millivolts, largest value written to a window entry
  localparam int unsigned MvMax = 5000;

  // sample * 5000 / 4095 as a multiply by ceil(5000 * 2^24 / 4095) and a shift by 24,
  // exact over the whole 12-bit range since 4095^2 < 2^24
  localparam int unsigned    MvFrac   = 24;
  localparam int unsigned    MvRecipW = 25;
  localparam longint unsigned MvRecipL = ((64'd5000 << MvFrac) + 64'd4094) / 64'd4095;
  localparam logic [MvRecipW-1:0] MvRecip = MvRecipW'(MvRecipL);
  localparam int unsigned    MvProdW  = SampleW + MvRecipW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAvgEnable = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHoldMs    = 1'b1;

  localparam logic [HoldW-1:0] HoldMsReset = 16'd5000;

  // operating modes
  typedef enum logic [1:0] {
    ModeWait   = 2'd0,
    ModeListen = 2'd1,
    ModePause  = 2'd2,
    ModeWarn   = 2'd3
  } mode_e;

  // window update request from the control stage
  typedef struct packed {
    logic           push;
    logic [MvW-1:0] mv;
  } win_req_t;

endpackage : hsm_pkg

`default_nettype wire

[rtl/core/hsm_window.sv]
// hsm_window: running-sum moving average over the last WINDOW_LEN millivolt values
// depends on hsm_pkg (win_req_t, MvW, MvMax)
`default_nettype none

module hsm_window #(
  parameter int unsigned WINDOW_LEN = 150
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  upd_i,    // commit the request this cycle
  input  hsm_pkg::win_req_t    req_i,
  output logic [hsm_pkg::MvW-1:0] avg_o
);
  import hsm_pkg::*;

  localparam int unsigned IdxW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SumW   = $clog2(WINDOW_LEN * MvMax + 1);
  // sum / WINDOW_LEN as multiply by ceil(2^ShiftK / WINDOW_LEN), exact for sums below 2^SumW
  localparam int unsigned ShiftK = SumW + $clog2(WINDOW_LEN);
  localparam int unsigned RecipW = SumW + 2;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam longint unsigned RecipL = ((64'd1 << ShiftK) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [RecipW-1:0] Recip   = RecipW'(RecipL);
  localparam logic [IdxW-1:0]   LastIdx = IdxW'(WINDOW_LEN - 1);

  logic [MvW-1:0]        mem_q [WINDOW_LEN];
  logic                  wrap_q;
  logic [IdxW-1:0]       idx_q, idx_nxt;
  logic [SumW-1:0]       sum_q, sum_new;
  logic [MvW-1:0]        rd_q, old_val;
  logic [ProdW-1:0]      avg_prod;

  // entry leaving the window; the window fills in order, so nothing leaves before the first wrap
  assign old_val = wrap_q ? rd_q : '0;

  // running sum update and division by the window length
  assign sum_new  = sum_q + SumW'(req_i.mv) - SumW'(old_val);
  assign avg_prod = ProdW'(sum_new) * ProdW'(Recip);
  assign avg_o    = req_i.push ? avg_prod[ShiftK +: MvW] : '0;

  assign idx_nxt = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);

  // index, sum and wrap flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      wrap_q <= 1'b0;
    end else if (upd_i && req_i.push) begin
      idx_q <= idx_nxt;
      sum_q <= sum_new;
      if (idx_q == LastIdx) wrap_q <= 1'b1;
    end
  end

  // window memory: write the new entry, prefetch the next one to leave
  always_ff @(posedge clk_i) begin
    if (upd_i && req_i.push) begin
      mem_q[idx_q] <= req_i.mv;
      rd_q         <= (idx_nxt == idx_q) ? req_i.mv : mem_q[idx_nxt];
    end
  end

endmodule : hsm_window

`default_nettype wire

[rtl/core/hall_sensor_monitor.sv]
// hall_sensor_monitor: mode control, millivolt scaling, hold timer and moving average for a hall sensor
// depends on hsm_pkg and hsm_window
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: adc_sample, hall_level, button_pressed, now_ms
//   m_axis    out  tvalid/tready          tdata: mode_after, millivolts, average_mv, hall_out
//                                         tuser: sample_valid
//   cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// one transaction per cycle while m_axis_tready is high; each result passes the input
// register, the scaling and mode stage and the averaging stage into the output register
// each stage moves on when the next one is empty or emptying, so bubbles close up
// reset leaves the mode in wait, clears the hold timer and empties the window through a
// wrap flag, since entries fill in order, so the block takes transactions right after reset
`default_nettype none

module hall_sensor_monitor #(
  parameter int unsigned WINDOW_LEN = 150
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // input stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [47:0]                  s_axis_tdata,  // adc_sample[11:0], hall_level[12],
                                                      // button_pressed[13], now_ms[45:14]
  // result stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // mode_after[1:0], millivolts[14:2],
                                                      // average_mv[27:15], hall_out[28]
  output logic                         m_axis_tuser,  // sample_valid[0]
  // configuration writes
  input  wire                          cfg_we_i,
  input  wire  [hsm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [hsm_pkg::CfgW-1:0]     cfg_data_i
);
  import hsm_pkg::*;

  // configuration registers
  logic             avg_en_q;
  logic [HoldW-1:0] hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_en_q  <= 1'b0;
      hold_ms_q <= HoldMsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAvgEnable: avg_en_q  <= cfg_data_i[0];
        CfgHoldMs:    hold_ms_q <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v0_q, v1_q, vo_q;
  logic out_adv, adv0, adv1, accept;

  assign out_adv       = !vo_q || m_axis_tready;
  assign adv1          = v1_q && out_adv;
  assign s_axis_tready = !v0_q || !v1_q || out_adv;
  assign adv0          = v0_q && (!v1_q || out_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept)    v0_q <= 1'b1;
      else if (adv0) v0_q <= 1'b0;
      if (adv0)      v1_q <= 1'b1;
      else if (adv1) v1_q <= 1'b0;
      if (adv1)      vo_q <= 1'b1;
      else if (m_axis_tready) vo_q <= 1'b0;
    end
  end

  // input register
  logic [SampleW-1:0] s0_sample_q;
  logic               s0_hall_q, s0_button_q;
  logic [TimeW-1:0]   s0_now_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_sample_q <= s_axis_tdata[11:0];
      s0_hall_q   <= s_axis_tdata[12];
      s0_button_q <= s_axis_tdata[13];
      s0_now_q    <= s_axis_tdata[45:14];
    end
  end

  // millivolt scaling
  logic [MvProdW-1:0] mv_prod;
  logic [MvW-1:0]     mv;

  assign mv_prod = MvProdW'(s0_sample_q) * MvProdW'(MvRecip);
  assign mv      = mv_prod[MvFrac +: MvW];

  // mode machine and hold timer
  mode_e            mode_q, mode_d;
  logic             hold_act_q, hold_act_d;
  logic [TimeW-1:0] hold_start_q, hold_start_d;
  logic [TimeW-1:0] elapsed;
  logic             listen;

  assign elapsed = s0_now_q - hold_start_q;
  assign listen  = (mode_q == ModeListen);

  always_comb begin
    mode_d       = mode_q;
    hold_act_d   = hold_act_q;
    hold_start_d = hold_start_q;
    case (mode_q)
      ModeWait: begin
        if (s0_button_q) mode_d = ModeListen;
      end
      ModeListen: begin
        if (s0_hall_q) begin
          if (!hold_act_q) begin
            hold_act_d   = 1'b1;
            hold_start_d = s0_now_q;
          end else if (elapsed >= TimeW'(hold_ms_q)) begin
            mode_d     = ModeWarn;
            hold_act_d = 1'b0;
          end
        end else begin
          hold_act_d = 1'b0;
        end
        // button wins over the hold timeout
        if (s0_button_q) mode_d = ModePause;
      end
      ModePause: begin
        hold_act_d = 1'b0;
        if (s0_button_q) mode_d = ModeListen;
      end
      default: begin
        if (s0_button_q) mode_d = ModeWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeWait;
      hold_act_q   <= 1'b0;
      hold_start_q <= '0;
    end else if (adv0) begin
      mode_q       <= mode_d;
      hold_act_q   <= hold_act_d;
      hold_start_q <= hold_start_d;
    end
  end

  // mode stage register
  mode_e          s1_mode_q;
  logic           s1_valid_q, s1_hall_q, s1_push_q;
  logic [MvW-1:0] s1_mv_q;

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      s1_mode_q  <= mode_d;
      s1_valid_q <= listen;
      s1_hall_q  <= listen && s0_hall_q;
      s1_push_q  <= listen && avg_en_q;
      s1_mv_q    <= listen ? mv : '0;
    end
  end

  // moving average
  win_req_t       win_req;
  logic [MvW-1:0] avg;

  assign win_req.push = s1_push_q;
  assign win_req.mv   = s1_mv_q;

  hsm_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv1),
    .req_i  (win_req),
    .avg_o  (avg)
  );

  // output register
  logic [1:0]     out_mode_q;
  logic           out_valid_q, out_hall_q;
  logic [MvW-1:0] out_mv_q, out_avg_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      out_mode_q  <= s1_mode_q;
      out_valid_q <= s1_valid_q;
      out_hall_q  <= s1_hall_q;
      out_mv_q    <= s1_mv_q;
      out_avg_q   <= avg;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {3'b000, out_hall_q, out_avg_q, out_mv_q, out_mode_q};
  assign m_axis_tuser  = out_valid_q;

endmodule : hall_sensor_monitor

`default_nettype wire
